>>> rtl/tsad_pkg.sv
package tsad_pkg;

	localparam int POS_W = 32;
	localparam int DT_W = 32;
	localparam int ALT_CFG_W = 16;
	localparam int SPD_W = 48;
	localparam int ALT_W = 64;
	localparam int DIST_W = 33;
	localparam int RAD_W = 66;
	localparam int ROOT_REM_W = 35;
	localparam int SPD_PROD_W = 45;
	localparam int ALT_PROD_W = 43;
	localparam int ROOT_STEPS = DIST_W;

	localparam logic [11:0] SPEED_MUL = 12'd3600;
	localparam logic [9:0] ALT_MUL = 10'd1000;
	localparam logic [ALT_CFG_W-1:0] START_ALT_RST = 16'd5000;

	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic root_step;
		logic spd_init;
		logic acc_init;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic dt_zero;
	} sts_t;

endpackage

>>> rtl/tsad_if.sv
interface tsad_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] x_position;
	logic signed [31:0] y_position;
	logic [31:0] frame_interval;

	modport source (output valid, output x_position, output y_position,
		output frame_interval, input ready);
	modport sink (input valid, input x_position, input y_position,
		input frame_interval, output ready);
endinterface

interface tsad_out_if;
	logic valid;
	logic ready;
	logic [47:0] speed_knots;
	logic signed [47:0] accel_knots_per_s;
	logic [63:0] altitude_feet;
	logic interval_error;

	modport source (output valid, output speed_knots, output accel_knots_per_s,
		output altitude_feet, output interval_error, input ready);
	modport sink (input valid, input speed_knots, input accel_knots_per_s,
		input altitude_feet, input interval_error, output ready);
endinterface

>>> rtl/tsad_dp.sv
module tsad_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  tsad_pkg::cmd_t cmd,
	output tsad_pkg::sts_t sts,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic signed [31:0] x_position,
	input  logic signed [31:0] y_position,
	input  logic [31:0] frame_interval,
	output logic [47:0] speed_knots,
	output logic signed [47:0] accel_knots_per_s,
	output logic [63:0] altitude_feet,
	output logic interval_error
);

	localparam int NW = tsad_pkg::SPD_W + FRAC_BITS;
	localparam int SW = tsad_pkg::SPD_W;

	logic [15:0] start_alt_q;
	logic signed [31:0] last_x_q, last_y_q;
	logic [SW-1:0] last_speed_q, spd_q;
	logic [63:0] alt_q;
	logic first_q;
	logic [31:0] ax_q, ay_q, dt_q;
	logic [tsad_pkg::RAD_W-1:0] sum_q;
	logic [tsad_pkg::ROOT_REM_W-1:0] rem_q;
	logic [tsad_pkg::DIST_W-1:0] root_q;
	logic [NW-1:0] num_q;
	logic [31:0] drem_q;
	logic neg_q;

	logic signed [32:0] dx, dy, ndx, ndy;
	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [tsad_pkg::ROOT_REM_W+1:0] rrem, trial;
	logic [32:0] drem_ext, drem_sub;
	logic div_ge;
	logic [tsad_pkg::SPD_PROD_W-1:0] d3600;
	logic [tsad_pkg::ALT_PROD_W-1:0] d1000;
	logic [64:0] alt_sum;
	logic [SW-1:0] spd_sat, mag, acc_val;
	logic spd_lt;

	assign dx = {x_position[31], x_position} - {last_x_q[31], last_x_q};
	assign dy = {y_position[31], y_position} - {last_y_q[31], last_y_q};
	assign ndx = -dx;
	assign ndy = -dy;

	assign mul_a = cmd.sq_y ? ay_q : ax_q;
	assign prod = 64'(mul_a) * 64'(mul_a);

	assign rrem = {rem_q, sum_q[tsad_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	assign drem_ext = {drem_q, num_q[NW-1]};
	assign drem_sub = drem_ext - {1'b0, dt_q};
	assign div_ge = drem_ext >= {1'b0, dt_q};

	assign d3600 = tsad_pkg::SPD_PROD_W'(root_q) * tsad_pkg::SPD_PROD_W'(tsad_pkg::SPEED_MUL);
	assign d1000 = tsad_pkg::ALT_PROD_W'(root_q) * tsad_pkg::ALT_PROD_W'(tsad_pkg::ALT_MUL);
	assign alt_sum = {1'b0, alt_q} + 65'(d1000);

	assign spd_sat = (|num_q[NW-1:SW]) ? '1 : num_q[SW-1:0];
	assign spd_lt = spd_sat < last_speed_q;
	assign mag = spd_lt ? last_speed_q - spd_sat : spd_sat - last_speed_q;

	always_comb begin
		if (neg_q) begin
			if ((|num_q[NW-1:SW]) || (num_q[SW-1] && (|num_q[SW-2:0])))
				acc_val = {1'b1, {(SW-1){1'b0}}};
			else
				acc_val = -num_q[SW-1:0];
		end else begin
			if (|num_q[NW-1:SW-1])
				acc_val = {1'b0, {(SW-1){1'b1}}};
			else
				acc_val = num_q[SW-1:0];
		end
	end

	assign sts.first = first_q;
	assign sts.dt_zero = (dt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_alt_q <= tsad_pkg::START_ALT_RST;
			last_x_q <= '0;
			last_y_q <= '0;
			last_speed_q <= '0;
			alt_q <= 64'(tsad_pkg::START_ALT_RST) << FRAC_BITS;
			first_q <= 1'b1;
		end else begin
			if (cfg_we)
				start_alt_q <= cfg_wdata;
			if (cmd.load) begin
				last_x_q <= x_position;
				last_y_q <= y_position;
				if (first_q) begin
					alt_q <= 64'(start_alt_q) << FRAC_BITS;
					first_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				alt_q <= alt_sum[64] ? '1 : alt_sum[63:0];
				if (!sts.dt_zero)
					last_speed_q <= spd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= dx[32] ? ndx[31:0] : dx[31:0];
			ay_q <= dy[32] ? ndy[31:0] : dy[31:0];
			dt_q <= frame_interval;
		end
		if (cmd.sq_x)
			sum_q <= tsad_pkg::RAD_W'(prod);
		if (cmd.sq_y) begin
			sum_q <= sum_q + tsad_pkg::RAD_W'(prod);
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			sum_q <= sum_q << 2;
			if (rrem >= trial) begin
				rem_q <= tsad_pkg::ROOT_REM_W'(rrem - trial);
				root_q <= {root_q[tsad_pkg::DIST_W-2:0], 1'b1};
			end else begin
				rem_q <= tsad_pkg::ROOT_REM_W'(rrem);
				root_q <= {root_q[tsad_pkg::DIST_W-2:0], 1'b0};
			end
		end
		if (cmd.spd_init) begin
			num_q <= {SW'(d3600), {FRAC_BITS{1'b0}}};
			drem_q <= '0;
		end
		if (cmd.acc_init) begin
			spd_q <= spd_sat;
			neg_q <= spd_lt;
			num_q <= {mag, {FRAC_BITS{1'b0}}};
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= div_ge ? drem_sub[31:0] : drem_ext[31:0];
			num_q <= {num_q[NW-2:0], div_ge};
		end
		if (cmd.finish) begin
			altitude_feet <= alt_sum[64] ? '1 : alt_sum[63:0];
			interval_error <= sts.dt_zero;
			speed_knots <= sts.dt_zero ? '0 : spd_q;
			accel_knots_per_s <= sts.dt_zero ? '0 : acc_val;
		end
	end

endmodule

>>> rtl/tsad_ctrl.sv
module tsad_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  tsad_pkg::sts_t sts,
	output tsad_pkg::cmd_t cmd
);

	localparam int NW = tsad_pkg::SPD_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQX  = 9'b000000010,
		S_SQY  = 9'b000000100,
		S_ROOT = 9'b000001000,
		S_SPDI = 9'b000010000,
		S_SPD  = 9'b000100000,
		S_ACCI = 9'b001000000,
		S_ACC  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;
	logic root_last, div_last;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;
	assign root_last = (cnt_q == CW'(tsad_pkg::ROOT_STEPS - 1));
	assign div_last = (cnt_q == CW'(NW - 1));

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.first)
						state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.sq_x = 1'b1;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.sq_y = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (root_last)
					state_d = sts.dt_zero ? S_FIN : S_SPDI;
			end
			S_SPDI: begin
				cmd.spd_init = 1'b1;
				state_d = S_SPD;
			end
			S_SPD: begin
				cmd.div_step = 1'b1;
				if (div_last)
					state_d = S_ACCI;
			end
			S_ACCI: begin
				cmd.acc_init = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.div_step = 1'b1;
				if (div_last)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sq_y || cmd.spd_init || cmd.acc_init)
				cnt_q <= '0;
			else if (cmd.root_step || cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not presented");
	a_root_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && root_last) |=> (state_q == S_FIN || state_q == S_SPDI))
		else $error("root did not finish");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPD && div_last) |=> (state_q == S_ACCI))
		else $error("speed divide length wrong");

endmodule

>>> rtl/track_speed_accel_deriver_unit.sv
// channel  | dir | payload
// in_ch    | in  | x_position, y_position, frame_interval
// out_ch   | out | speed_knots, accel_knots_per_s, altitude_feet, interval_error
// cfg      | in  | cfg_we, cfg_wdata (start_altitude)
// First frame after reset only stores the track start and gives no result.
// Later frames: load, square x, square y, 33 root steps, then a speed division and an accel
// division of one step per numerator bit each, then finish; a zero interval skips the divisions.
// The root and the dividers advance one bit a cycle; in_ch.ready is high only when idle.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset clears the track and loads the accumulator from 5000 feet.
module track_speed_accel_deriver_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tsad_in_if.sink in_ch,
	tsad_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata
);

	tsad_pkg::cmd_t cmd;
	tsad_pkg::sts_t sts;

	tsad_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	tsad_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.x_position(in_ch.x_position),
		.y_position(in_ch.y_position),
		.frame_interval(in_ch.frame_interval),
		.speed_knots(out_ch.speed_knots),
		.accel_knots_per_s(out_ch.accel_knots_per_s),
		.altitude_feet(out_ch.altitude_feet),
		.interval_error(out_ch.interval_error)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int FB = 16;
	localparam int QUIET_LIMIT = 5000;
	localparam int N_RANDOM = 830;

	typedef struct packed {
		logic [tsad_pkg::SPD_W-1:0] speed;
		logic [tsad_pkg::SPD_W-1:0] accel;
		logic [tsad_pkg::ALT_W-1:0] alt;
		logic err;
	} track_res_t;

	class track_scoreboard;
		logic [tsad_pkg::ALT_CFG_W-1:0] start_alt;
		logic signed [tsad_pkg::POS_W-1:0] prev_x, prev_y;
		logic [tsad_pkg::SPD_W-1:0] prev_speed;
		logic [tsad_pkg::ALT_W-1:0] alt_sum;
		bit first;
		track_res_t pending[$];
		int mismatches;

		function new();
			start_alt = tsad_pkg::START_ALT_RST;
			prev_x = '0;
			prev_y = '0;
			prev_speed = '0;
			alt_sum = 64'(tsad_pkg::START_ALT_RST) << FB;
			first = 1;
			mismatches = 0;
		endfunction

		function logic [127:0] scaled_quot(logic [63:0] v, logic [31:0] d, logic [127:0] lim);
			logic [127:0] q;
			q = ({64'b0, v} << FB) / {96'b0, d};
			return (q > lim) ? lim : q;
		endfunction

		function void note(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] dt);
			longint dx, dy;
			logic [127:0] ax, ay, sum, r, c, q, mag;
			logic [63:0] step_len, add;
			track_res_t e;
			if (first) begin
				prev_x = x;
				prev_y = y;
				alt_sum = 64'(start_alt) << FB;
				first = 0;
				return;
			end
			dx = longint'(x) - longint'(prev_x);
			dy = longint'(y) - longint'(prev_y);
			ax = (dx < 0) ? 128'(-dx) : 128'(dx);
			ay = (dy < 0) ? 128'(-dy) : 128'(dy);
			sum = ax * ax + ay * ay;
			r = '0;
			for (int b = 33; b >= 0; b--) begin
				c = r | (128'd1 << b);
				if (c * c <= sum) r = c;
			end
			step_len = r[63:0];
			e = '0;
			if (dt == 0) begin
				e.err = 1;
			end else begin
				q = scaled_quot(step_len * 64'd3600, dt, 128'hFFFF_FFFF_FFFF);
				e.speed = q[47:0];
				if (e.speed < prev_speed) begin
					mag = scaled_quot(64'(prev_speed - e.speed), dt, 128'h8000_0000_0000);
					e.accel = 48'(0) - mag[47:0];
				end else begin
					mag = scaled_quot(64'(e.speed - prev_speed), dt, 128'h7FFF_FFFF_FFFF);
					e.accel = mag[47:0];
				end
				prev_speed = e.speed;
			end
			add = step_len * 64'd1000;
			alt_sum = (alt_sum > ~64'd0 - add) ? ~64'd0 : alt_sum + add;
			e.alt = alt_sum;
			prev_x = x;
			prev_y = y;
			pending.push_back(e);
		endfunction

		function void check(track_res_t got);
			track_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.speed !== e.speed || got.accel !== e.accel || got.alt !== e.alt ||
					got.err !== e.err) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp spd %h acc %h alt %h err %b, ",
						"got spd %h acc %h alt %h err %b"},
						e.speed, e.accel, e.alt, e.err, got.speed, got.accel, got.alt, got.err);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = '0;
	bit quiet = 0;
	int idle_cycles = 0;
	logic signed [31:0] cur_x = 0, cur_y = 0;

	tsad_in_if in_ch();
	tsad_out_if out_ch();

	track_scoreboard sb = new();

	track_speed_accel_deriver_unit #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.x_position = '0;
		in_ch.y_position = '0;
		in_ch.frame_interval = '0;
		out_ch.ready = 0;
	end

	// request and result monitors: handshake is settled at the falling edge
	always @(negedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note(in_ch.x_position, in_ch.y_position, in_ch.frame_interval);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check({out_ch.speed_knots, out_ch.accel_knots_per_s, out_ch.altitude_feet,
				out_ch.interval_error});
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 6);
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1;
		end
	end

	task automatic write_start_alt(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_frame(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] dt);
		int gap;
		in_ch.valid <= 1;
		in_ch.x_position <= x;
		in_ch.y_position <= y;
		in_ch.frame_interval <= dt;
		cur_x = x;
		cur_y = y;
		forever begin
			@(negedge clk);
			if (in_ch.ready) break;
		end
		@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] x, y;
		logic [31:0] dt;
		int sel;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_start_alt(16'd0);
		sb.start_alt = 16'd0;
		write_start_alt(16'hFFFF);
		sb.start_alt = 16'hFFFF;

		send_frame(32'sh0, 32'sh0, 32'h10000);
		send_frame(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'h1);
		send_frame(32'sh80000000, 32'sh80000000, 32'hFFFFFFFF);
		send_frame(32'sh80000000, 32'sh80000000, 32'h1);
		send_frame(32'sh7FFFFFFF, 32'sh80000000, 32'h0);
		send_frame(32'sh7FFFFFFF, 32'sh80000000, 32'h10000);
		send_frame(32'sh7FFF0000, 32'sh80010000, 32'h10000);
		send_frame(32'sh7FFF0000, 32'sh80010000, 32'h1);
		send_frame(32'sh0, 32'sh0, 32'h8000);
		send_frame(32'sh10000, 32'sh0, 32'h10000);
		send_frame(32'sh10000, 32'sh10000, 32'h0);
		send_frame(32'shFFFFFFFF, 32'sh1, 32'hFFFFFFFF);
		send_frame(32'sh80000000, 32'sh7FFFFFFF, 32'h7FFFFFFF);
		drain();
		write_start_alt(16'd0);
		sb.start_alt = 16'd0;

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				drain();
				write_start_alt(16'($urandom));
				sb.start_alt = cfg_wdata;
			end
			if (i > N_RANDOM * 85 / 100) quiet = 1;
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				x = $urandom;
				y = $urandom;
				dt = $urandom;
			end else begin
				x = cur_x + $signed($urandom_range(0, 8192)) - 4096;
				y = cur_y + $signed($urandom_range(0, 8192)) - 4096;
				dt = (sel < 20) ? 32'h0 : $urandom_range(1, 32'h40000);
			end
			send_frame(x, y, dt);
		end
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
